>>> rtl/rae_pkg.sv
// Shared constants and operation codes for the range extremes sparse table block.
// Used by the front, back and top level; depends on nothing.
package rae_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int TABLE_LEVELS = 11;
    localparam int VALUE_BITS   = 32;
    localparam int CFG_WIDTH    = 11;
    localparam int QUEUE_DEPTH  = 4;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

endpackage

>>> rtl/rae_if.sv
// Valid/ready channels for input beats and result beats.
// Standalone; field widths are fixed by the block's item format.
interface rae_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [9:0]         element_index;
    logic signed [31:0] element_value;
    logic [9:0]         range_start;
    logic [9:0]         range_end;

    modport source (output valid, operation, element_index, element_value,
                    range_start, range_end, input ready);
    modport sink   (input valid, operation, element_index, element_value,
                    range_start, range_end, output ready);
endinterface

interface rae_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] range_max;
    logic signed [31:0] range_min;
    logic signed [31:0] nonpos_max;
    logic               nonpos_found;
    logic [30:0]        nonneg_min;
    logic               nonneg_found;
    logic               range_error;

    modport source (output valid, range_max, range_min, nonpos_max, nonpos_found,
                    nonneg_min, nonneg_found, range_error, input ready);
    modport sink   (input valid, range_max, range_min, nonpos_max, nonpos_found,
                    nonneg_min, nonneg_found, range_error, output ready);
endinterface

>>> rtl/rae_fifo.sv
// Small command queue between the front and back parts.
// Depends on nothing; width and depth come from the instantiating module.
module rae_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_slot[r_rd_ptr];

    // pointers wrap at the queue depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end
endmodule

>>> rtl/rae_front.sv
// Front part: accepts input beats, drops ignored ones, checks query ranges and
// forms table addresses. Depends on rae_pkg and rae_in_if.
module rae_front #(
    parameter int MAX_ELEMENTS = rae_pkg::MAX_ELEMENTS,
    parameter int TABLE_LEVELS = rae_pkg::TABLE_LEVELS,
    parameter int VALUE_BITS   = rae_pkg::VALUE_BITS,
    parameter int NW           = 11,
    parameter int QW           = 8
) (
    rae_in_if.sink           i_in,
    input  logic [NW-1:0]    i_used,
    input  logic             i_full,
    output logic             o_push,
    output logic [QW-1:0]    o_item
);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int LW = $clog2(TABLE_LEVELS);
    localparam int MW = LW + AW;

    rae_pkg::t_op        op;
    logic                take;
    logic [NW-1:0]       l_ext, r_ext, len, b_idx;
    logic [LW-1:0]       lvl;
    logic                err;
    logic [MW-1:0]       addr_a, addr_b;
    logic [VALUE_BITS-1:0] value;

    assign i_in.ready = !i_full;
    assign op    = rae_pkg::t_op'(i_in.operation);
    assign take  = i_in.valid && !i_full;
    assign value = VALUE_BITS'($unsigned(i_in.element_value));

    // range check and level choice for queries
    always_comb begin
        l_ext = NW'(i_in.range_start);
        r_ext = NW'(i_in.range_end);
        err   = (l_ext > r_ext) || (r_ext >= i_used);
        len   = r_ext - l_ext + 1'b1;
        lvl   = '0;
        for (int k = 1; k < TABLE_LEVELS; k++) begin
            if ((NW'(1) << k) <= len) begin
                lvl = LW'(k);
            end
        end
        b_idx = r_ext + 1'b1 - (NW'(1) << lvl);
    end

    // address fields; a load carries its write address in the first slot
    always_comb begin
        case (op)
            rae_pkg::OP_LOAD: begin
                addr_a = {LW'(0), AW'(i_in.element_index)};
                addr_b = '0;
                o_push = take && (NW'(i_in.element_index) < NW'(MAX_ELEMENTS));
            end
            rae_pkg::OP_BUILD: begin
                addr_a = '0;
                addr_b = '0;
                o_push = take;
            end
            rae_pkg::OP_QUERY: begin
                addr_a = {lvl, AW'(l_ext)};
                addr_b = {lvl, AW'(b_idx)};
                o_push = take;
            end
            default: begin
                addr_a = '0;
                addr_b = '0;
                o_push = 1'b0;
            end
        endcase
    end

    assign o_item = {i_in.operation, err, value, addr_a, addr_b};
endmodule

>>> rtl/rae_back.sv
// Back part: table memory, build sequencer, query read and result register.
// Depends on rae_pkg and rae_out_if; takes commands from the queue head.
module rae_back #(
    parameter int MAX_ELEMENTS = rae_pkg::MAX_ELEMENTS,
    parameter int TABLE_LEVELS = rae_pkg::TABLE_LEVELS,
    parameter int VALUE_BITS   = rae_pkg::VALUE_BITS,
    parameter int NW           = 11,
    parameter int QW           = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [NW-1:0]    i_used,
    input  logic [QW-1:0]    i_item,
    input  logic             i_empty,
    output logic             o_pop,
    rae_out_if.source        o_out
);
    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int LW    = $clog2(TABLE_LEVELS);
    localparam int MW    = LW + AW;
    localparam int V     = VALUE_BITS;
    localparam int EW    = 4 * V + 2;
    localparam int DEPTH = TABLE_LEVELS << AW;
    // entry layout: max | min | nonpos value, ok | nonneg value, ok
    localparam int O_NNOK = 0;
    localparam int O_NN   = 1;
    localparam int O_NPOK = V + 1;
    localparam int O_NP   = V + 2;
    localparam int O_MIN  = 2 * V + 2;
    localparam int O_MAX  = 3 * V + 2;

    typedef enum logic [1:0] {ST_IDLE, ST_BCHK, ST_BWR} t_state;

    function automatic logic [EW-1:0] f_merge(input logic [EW-1:0] a,
                                              input logic [EW-1:0] b);
        logic [EW-1:0] m;
        logic          a_ok, b_ok;
        m    = '0;
        m[O_MAX +: V] = ($signed(a[O_MAX +: V]) > $signed(b[O_MAX +: V])) ?
                        a[O_MAX +: V] : b[O_MAX +: V];
        m[O_MIN +: V] = ($signed(a[O_MIN +: V]) < $signed(b[O_MIN +: V])) ?
                        a[O_MIN +: V] : b[O_MIN +: V];
        a_ok = a[O_NPOK];
        b_ok = b[O_NPOK];
        if (a_ok && b_ok) begin
            m[O_NP +: V] = ($signed(a[O_NP +: V]) > $signed(b[O_NP +: V])) ?
                           a[O_NP +: V] : b[O_NP +: V];
        end else begin
            m[O_NP +: V] = a_ok ? a[O_NP +: V] : b[O_NP +: V];
        end
        m[O_NPOK] = a_ok || b_ok;
        a_ok = a[O_NNOK];
        b_ok = b[O_NNOK];
        if (a_ok && b_ok) begin
            m[O_NN +: V] = ($signed(a[O_NN +: V]) < $signed(b[O_NN +: V])) ?
                           a[O_NN +: V] : b[O_NN +: V];
        end else begin
            m[O_NN +: V] = a_ok ? a[O_NN +: V] : b[O_NN +: V];
        end
        m[O_NNOK] = a_ok || b_ok;
        return m;
    endfunction

    // queue head fields
    logic [1:0]    h_op;
    logic          h_err;
    logic [V-1:0]  h_value;
    logic [MW-1:0] h_addr_a, h_addr_b;
    assign {h_op, h_err, h_value, h_addr_a, h_addr_b} = i_item;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] r_rd_a, r_rd_b;

    t_state        r_state, n_state;
    logic [LW:0]   r_lvl, n_lvl;
    logic [NW-1:0] r_idx, n_idx;
    logic          r_s1, n_s1;
    logic          r_s1_err, n_s1_err;

    logic          rd_en, wr_en;
    logic [MW-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic [EW-1:0] wr_data, load_entry, q_entry;
    logic [NW:0]   span, reach;
    logic          out_free, v_nonpos, v_nonneg;

    assign out_free = !o_out.valid || o_out.ready;
    assign span     = (NW + 1)'(1) << r_lvl;
    assign reach    = (NW + 1)'(r_idx) + span;

    // level 0 entry for a loaded element
    always_comb begin
        v_nonpos   = h_value[V-1] || (h_value == '0);
        v_nonneg   = !h_value[V-1];
        load_entry = '0;
        load_entry[O_MAX +: V] = h_value;
        load_entry[O_MIN +: V] = h_value;
        load_entry[O_NP +: V]  = v_nonpos ? h_value : '0;
        load_entry[O_NPOK]     = v_nonpos;
        load_entry[O_NN +: V]  = v_nonneg ? h_value : '0;
        load_entry[O_NNOK]     = v_nonneg;
    end

    // command dispatch and build sequencing
    always_comb begin
        n_state   = r_state;
        n_lvl     = r_lvl;
        n_idx     = r_idx;
        n_s1      = 1'b0;
        n_s1_err  = r_s1_err;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        rd_addr_a = h_addr_a;
        rd_addr_b = h_addr_b;
        wr_addr   = h_addr_a;
        wr_data   = load_entry;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    case (h_op)
                        rae_pkg::OP_LOAD: begin
                            o_pop = 1'b1;
                            wr_en = 1'b1;
                        end
                        rae_pkg::OP_BUILD: begin
                            o_pop   = 1'b1;
                            n_state = ST_BCHK;
                            n_lvl   = (LW + 1)'(1);
                            n_idx   = '0;
                        end
                        rae_pkg::OP_QUERY: begin
                            if (!r_s1 && out_free) begin
                                o_pop    = 1'b1;
                                rd_en    = 1'b1;
                                n_s1     = 1'b1;
                                n_s1_err = h_err;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_BCHK: begin
                rd_addr_a = {LW'(r_lvl - 1'b1), AW'(r_idx)};
                rd_addr_b = {LW'(r_lvl - 1'b1), AW'(r_idx + NW'(span >> 1))};
                if (r_lvl == (LW + 1)'(TABLE_LEVELS)) begin
                    n_state = ST_IDLE;
                end else if (reach <= (NW + 1)'(i_used)) begin
                    rd_en   = 1'b1;
                    n_state = ST_BWR;
                end else begin
                    n_lvl = r_lvl + 1'b1;
                    n_idx = '0;
                end
            end
            ST_BWR: begin
                wr_en   = 1'b1;
                wr_addr = {LW'(r_lvl), AW'(r_idx)};
                wr_data = f_merge(r_rd_a, r_rd_b);
                n_idx   = r_idx + 1'b1;
                n_state = ST_BCHK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign q_entry = f_merge(r_rd_a, r_rd_b);

    // table memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= mem[rd_addr_a];
            r_rd_b <= mem[rd_addr_b];
        end
    end

    // state, query stage and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lvl       <= '0;
            r_idx       <= '0;
            r_s1        <= 1'b0;
            r_s1_err    <= 1'b0;
            o_out.valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lvl    <= n_lvl;
            r_idx    <= n_idx;
            r_s1     <= n_s1;
            r_s1_err <= n_s1_err;
            if (r_s1) begin
                o_out.valid <= 1'b1;
            end else if (o_out.ready) begin
                o_out.valid <= 1'b0;
            end
        end
        if (r_s1) begin
            if (r_s1_err) begin
                o_out.range_max    <= '0;
                o_out.range_min    <= '0;
                o_out.nonpos_max   <= '0;
                o_out.nonpos_found <= 1'b0;
                o_out.nonneg_min   <= '0;
                o_out.nonneg_found <= 1'b0;
                o_out.range_error  <= 1'b1;
            end else begin
                o_out.range_max    <= 32'(q_entry[O_MAX +: V]);
                o_out.range_min    <= 32'(q_entry[O_MIN +: V]);
                o_out.nonpos_max   <= q_entry[O_NPOK] ? 32'(q_entry[O_NP +: V]) : '0;
                o_out.nonpos_found <= q_entry[O_NPOK];
                o_out.nonneg_min   <= q_entry[O_NNOK] ? 31'(q_entry[O_NN +: V]) : '0;
                o_out.nonneg_found <= q_entry[O_NNOK];
                o_out.range_error  <= 1'b0;
            end
        end
    end
endmodule

>>> rtl/range_extremes_sparse_table_top.sv
// Query: via the queue, the table read registers and the result register; the back reads and
// merges one query before it takes the next. Load: one beat per cycle while the queue has room
// and the back is idle. Build: a read state, then a write on the single write port, per entry.
// A four-entry queue lets input beats arrive while a build runs or a result waits.
// Reset clears control, queue and element count (to MAX_ELEMENTS); tables hold
// garbage until loaded and built.
module range_extremes_sparse_table_top #(
    parameter int MAX_ELEMENTS = rae_pkg::MAX_ELEMENTS,
    parameter int TABLE_LEVELS = rae_pkg::TABLE_LEVELS,
    parameter int VALUE_BITS   = rae_pkg::VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rae_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    rae_in_if.sink                        i_in,
    rae_out_if.source                     o_out
);
    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int LW  = $clog2(TABLE_LEVELS);
    localparam int NW  = (AW + 1 > rae_pkg::CFG_WIDTH) ? AW + 1 : rae_pkg::CFG_WIDTH;
    localparam int QW  = 3 + VALUE_BITS + 2 * (LW + AW);

    logic [NW-1:0] r_count;
    logic [NW-1:0] used;
    logic          push, pop, empty, full;
    logic [QW-1:0] item, head;

    // element count register, clamped to the table size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= NW'(MAX_ELEMENTS);
        end else if (i_cfg_we) begin
            r_count <= NW'(i_cfg_wdata);
        end
    end
    assign used = (r_count > NW'(MAX_ELEMENTS)) ? NW'(MAX_ELEMENTS) : r_count;

    rae_front #(
        .MAX_ELEMENTS(MAX_ELEMENTS), .TABLE_LEVELS(TABLE_LEVELS),
        .VALUE_BITS(VALUE_BITS), .NW(NW), .QW(QW)
    ) u_front (
        .i_in   (i_in),
        .i_used (used),
        .i_full (full),
        .o_push (push),
        .o_item (item)
    );

    rae_fifo #(.WIDTH(QW), .DEPTH(rae_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    rae_back #(
        .MAX_ELEMENTS(MAX_ELEMENTS), .TABLE_LEVELS(TABLE_LEVELS),
        .VALUE_BITS(VALUE_BITS), .NW(NW), .QW(QW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_used  (used),
        .i_item  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

>>> rtl/rae_checker.sv
// Port-level checks on the result channel of the top level.
// Bound to range_extremes_sparse_table_top; depends on nothing else.
module rae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_range_max,
    input logic [31:0] i_range_min,
    input logic [31:0] i_nonpos_max,
    input logic        i_nonpos_found,
    input logic [30:0] i_nonneg_min,
    input logic        i_nonneg_found,
    input logic        i_range_error
);
    // no result beat right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // a stalled result beat stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result beat dropped while stalled");

    // an error beat carries only the error flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_range_error |-> i_range_max == '0 && i_range_min == '0 &&
        !i_nonpos_found && !i_nonneg_found)
        else $error("error beat with nonzero fields");

    // missing subsets report zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_nonpos_found || i_nonpos_max == '0) &&
        (i_nonneg_found || i_nonneg_min == '0))
        else $error("empty subset with nonzero value");
endmodule

bind range_extremes_sparse_table_top rae_checker u_rae_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_range_max    (o_out.range_max),
    .i_range_min    (o_out.range_min),
    .i_nonpos_max   (o_out.nonpos_max),
    .i_nonpos_found (o_out.nonpos_found),
    .i_nonneg_min   (o_out.nonneg_min),
    .i_nonneg_found (o_out.nonneg_found),
    .i_range_error  (o_out.range_error)
);

>>> sim/rae_checker.sv
// Result checker for the range extremes sparse table block: mirrors the four tables,
// predicts each query answer and compares result beats in order.
// Depends on rae_pkg and the rae_in_if / rae_out_if channel interfaces.
module rae_scoreboard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rae_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    rae_in_if                             in_ch,
    rae_out_if                            out_ch,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_answers_checked
);
    typedef struct {
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic signed [31:0] npv;
        logic               npok;
        logic signed [31:0] nnv;
        logic               nnok;
    } span_t;

    typedef struct packed {
        logic signed [31:0] rmax;
        logic signed [31:0] rmin;
        logic signed [31:0] np_max;
        logic               np_found;
        logic [30:0]        nn_min;
        logic               nn_found;
        logic               err;
    } answer_t;

    // mirrored tables, level by position
    span_t   levels [rae_pkg::TABLE_LEVELS][rae_pkg::MAX_ELEMENTS];
    logic [rae_pkg::CFG_WIDTH-1:0] count_reg;
    answer_t answers_due [$];

    function automatic span_t combine(span_t a, span_t b);
        span_t m;
        m.hi = (a.hi > b.hi) ? a.hi : b.hi;
        m.lo = (a.lo < b.lo) ? a.lo : b.lo;
        if (a.npok && b.npok) m.npv = (a.npv > b.npv) ? a.npv : b.npv;
        else                  m.npv = a.npok ? a.npv : b.npv;
        m.npok = a.npok || b.npok;
        if (a.nnok && b.nnok) m.nnv = (a.nnv < b.nnv) ? a.nnv : b.nnv;
        else                  m.nnv = a.nnok ? a.nnv : b.nnv;
        m.nnok = a.nnok || b.nnok;
        return m;
    endfunction

    function automatic int used_len();
        return (count_reg > rae_pkg::MAX_ELEMENTS) ? rae_pkg::MAX_ELEMENTS : int'(count_reg);
    endfunction

    task automatic rebuild_levels();
        int n;
        n = used_len();
        for (int j = 1; j < rae_pkg::TABLE_LEVELS; j++)
            for (int i = 0; i + (1 << j) <= n; i++)
                levels[j][i] = combine(levels[j-1][i], levels[j-1][i + (1 << (j-1))]);
    endtask

    function automatic answer_t range_answer(int l, int r);
        answer_t a;
        span_t   m;
        int      t;
        a = '0;
        if (l > r || r >= used_len()) begin
            a.err = 1'b1;
            return a;
        end
        t = 0;
        while (t + 1 < rae_pkg::TABLE_LEVELS && (1 << (t + 1)) <= r - l + 1) t++;
        m = combine(levels[t][l], levels[t][r + 1 - (1 << t)]);
        a.rmax     = m.hi;
        a.rmin     = m.lo;
        a.np_found = m.npok;
        a.np_max   = m.npok ? m.npv : '0;
        a.nn_found = m.nnok;
        a.nn_min   = m.nnok ? m.nnv[30:0] : '0;
        return a;
    endfunction

    // everything is stable at the falling edge, so beats are sampled there
    always @(negedge i_clk) begin
        answer_t got, want;
        span_t   e;
        logic signed [31:0] v;
        if (!i_rst_n) begin
            count_reg = rae_pkg::CFG_WIDTH'(rae_pkg::MAX_ELEMENTS);
            answers_due.delete();
        end else begin
            if (i_cfg_we) count_reg = i_cfg_wdata;
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.operation)
                    rae_pkg::OP_LOAD: begin
                        v = in_ch.element_value;
                        e.hi = v; e.lo = v;
                        e.npok = (v <= 0); e.npv = (v <= 0) ? v : '0;
                        e.nnok = (v >= 0); e.nnv = (v >= 0) ? v : '0;
                        levels[0][in_ch.element_index] = e;
                    end
                    rae_pkg::OP_BUILD: rebuild_levels();
                    rae_pkg::OP_QUERY: answers_due.push_back(
                        range_answer(in_ch.range_start, in_ch.range_end));
                    default: ;  // unused code, dropped by the block
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got.rmax     = out_ch.range_max;
                got.rmin     = out_ch.range_min;
                got.np_max   = out_ch.nonpos_max;
                got.np_found = out_ch.nonpos_found;
                got.nn_min   = out_ch.nonneg_min;
                got.nn_found = out_ch.nonneg_found;
                got.err      = out_ch.range_error;
                if (answers_due.size() == 0) begin
                    $display("%0t: result beat with no query outstanding: %p", $time, got);
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    o_answers_checked++;
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = answers_due.size();
    end

    initial begin
        o_fail_count      = 0;
        o_pending         = 0;
        o_answers_checked = 0;
        count_reg         = rae_pkg::CFG_WIDTH'(rae_pkg::MAX_ELEMENTS);
    end
endmodule

>>> sim/testbench.sv
// Top of the range extremes sparse table testbench: clock, reset, stimulus and verdict.
// Depends on rae_pkg, the channel interfaces, the block and rae_scoreboard.
module testbench;
    // operation code the block ignores
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [rae_pkg::CFG_WIDTH-1:0] i_cfg_wdata = '0;
    int   fail_count, pending, answers_checked;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_cycles = 0;
    int   hold_count = 0;
    int   phase_total = 0;
    int   loaded_upto = 0;

    rae_in_if  in_ch ();
    rae_out_if out_ch ();

    range_extremes_sparse_table_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_ch), .o_out(out_ch)
    );

    rae_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch), .o_fail_count(fail_count), .o_pending(pending),
        .o_answers_checked(answers_checked)
    );

    always #4 i_clk = ~i_clk;

    // result ready: random stalls, plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_cycles != 0 && hold_count < hold_cycles) begin
            out_ch.ready <= 1'b0;
            hold_count   <= hold_count + 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.operation     = rae_pkg::OP_LOAD;
        in_ch.element_index = '0;
        in_ch.element_value = '0;
        in_ch.range_start   = '0;
        in_ch.range_end     = '0;
        out_ch.ready        = 1'b0;
    end

    initial begin
        #(8 * 4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return $signed(32'($urandom_range(8))) - 32'sd4;
            default: return $signed($urandom);
        endcase
    endfunction

    // one input beat; valid stays high when the next beat follows at once
    task automatic send_beat(logic [1:0] op, logic [9:0] idx, logic signed [31:0] val,
                             logic [9:0] l, logic [9:0] r);
        logic took;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= op;
        in_ch.element_index <= idx;
        in_ch.element_value <= val;
        in_ch.range_start   <= l;
        in_ch.range_end     <= r;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic load_at(int idx, logic signed [31:0] val);
        send_beat(rae_pkg::OP_LOAD, 10'(idx), val, 10'($urandom), 10'($urandom));
    endtask

    task automatic query_range(int l, int r);
        send_beat(rae_pkg::OP_QUERY, 10'($urandom), $signed($urandom), 10'(l), 10'(r));
    endtask

    task automatic error_query(int n);
        int l, r;
        if (n < rae_pkg::MAX_ELEMENTS && $urandom_range(1)) begin
            r = $urandom_range(rae_pkg::MAX_ELEMENTS - 1, n);
            l = $urandom_range(rae_pkg::MAX_ELEMENTS - 1);
        end else begin
            l = $urandom_range(rae_pkg::MAX_ELEMENTS - 1, 1);
            r = $urandom_range(l - 1);
        end
        query_range(l, r);
    endtask

    task automatic good_query(int n);
        int l, r, d;
        l = $urandom_range(n - 1);
        d = $urandom_range(8);
        if ($urandom_range(1)) r = (l + d > n - 1) ? n - 1 : l + d;
        else                   r = $urandom_range(n - 1, l);
        query_range(l, r);
    endtask

    // drain: the closing query of a phase also trails any build in the queue
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(int n);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= rae_pkg::CFG_WIDTH'(n);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 62; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 62; end
            default: begin idle_pct = 25; stall_pct = 25; end
        endcase
    endtask

    // one setting of the element count: fill, build, then mixed traffic
    task automatic run_phase(int cfg, int beats, bit squeeze);
        int n, p;
        n = (cfg > rae_pkg::MAX_ELEMENTS) ? rae_pkg::MAX_ELEMENTS : cfg;
        write_count(cfg);
        set_idling(phase_total);
        for (int i = (n > 64 ? loaded_upto : 0); i < n; i++) load_at(i, pick_value());
        if (n > loaded_upto) loaded_upto = n;
        send_beat(rae_pkg::OP_BUILD, 10'($urandom), $signed($urandom), 10'($urandom),
                  10'($urandom));
        if (squeeze) begin
            idle_pct = 0;
            hold_cycles <= 400;
            repeat (40) good_query(n);
        end
        for (int k = 0; k < beats; k++) begin
            if (k == beats / 2) set_idling(phase_total + 1 + $urandom_range(2));
            p = $urandom_range(99);
            if (p < 60)      good_query(n);
            else if (p < 70) error_query(n);
            else if (p < 85) load_at($urandom_range(rae_pkg::MAX_ELEMENTS - 1), pick_value());
            else if (p < 93) send_beat(rae_pkg::OP_BUILD, 10'($urandom), $signed($urandom),
                                       10'($urandom), 10'($urandom));
            else             send_beat(OP_SPARE, 10'($urandom), $signed($urandom),
                                       10'($urandom), 10'($urandom));
        end
        good_query(n);
        settle();
        phase_total++;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, signs, zero, bad ranges, unused code
        write_count(8);
        load_at(0, 32'sh7fffffff);
        load_at(1, 32'sd5);
        load_at(2, 32'sh80000000);
        load_at(3, -32'sd7);
        load_at(4, 32'sd0);
        load_at(5, 32'sd1);
        load_at(6, -32'sd1);
        load_at(7, 32'sd100);
        send_beat(rae_pkg::OP_BUILD, '0, '0, '0, '0);
        query_range(0, 7);
        query_range(0, 1);
        query_range(2, 3);
        query_range(4, 4);
        query_range(3, 6);
        query_range(5, 2);
        query_range(0, 8);
        query_range(1023, 1023);
        send_beat(OP_SPARE, 10'h3ff, 32'sh7fffffff, 10'h3ff, 10'h3ff);
        load_at(4, -32'sd9);
        query_range(4, 4);
        query_range(0, 7);
        send_beat(rae_pkg::OP_BUILD, '0, '0, '0, '0);
        query_range(0, 7);
        settle();
        loaded_upto = 8;

        run_phase(1, 30, 1'b0);
        run_phase(2, 40, 1'b0);
        run_phase(3, 40, 1'b1);
        run_phase(17, 60, 1'b0);
        for (int i = 0; i < 6; i++) run_phase($urandom_range(40, 4), 40, 1'b0);
        run_phase(64, 60, 1'b0);
        run_phase(200, 60, 1'b0);
        run_phase(5, 40, 1'b0);

        repeat (50) @(posedge i_clk);
        $display("Covered %0d element-count settings, %0d query answers checked,",
                 phase_total + 1, answers_checked);
        $display("including bad ranges, stale tables and a long result back-pressure stall.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/rae_pkg.sv
rtl/rae_if.sv
rtl/rae_fifo.sv
rtl/rae_front.sv
rtl/rae_back.sv
rtl/range_extremes_sparse_table_top.sv
rtl/rae_checker.sv
sim/rae_checker.sv
sim/testbench.sv
